// ===== hw/rtl/rbsi_pkg.sv =====
// ============================================================================
// rbsi_pkg
// Shared types and constants for the ray/box slab intersection pipeline.
// ============================================================================
package rbsi_pkg;

    localparam int unsigned QBITS   = 31;             // quotient magnitude bits
    localparam int unsigned NUM_W   = 49;             // |(bound - origin) << 16|
    localparam int unsigned DEN_W   = 32;             // |direction|
    localparam int unsigned REM_W   = 64;
    localparam int unsigned DIV_LAT = QBITS + 2;      // register stages in divider
    localparam int unsigned NAXES   = 3;

    localparam logic [30:0]        QMAX      = 31'h7FFF_FFFF;
    localparam logic signed [31:0] QMAX_POS  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] QMAX_NEG  = -32'sh7FFF_FFFF;

    localparam logic [2:0] ADDR_PAR_THR = 3'd0;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic             neg;
    } t_div_in;

    typedef struct packed {
        logic par;
        logic in_slab;
    } t_axis_flags;

endpackage

// ===== hw/rtl/rbsi_prep.sv =====
// ============================================================================
// rbsi_prep
// Per-axis front end: slab numerators, divisor magnitude, parallel test.
// ============================================================================
module rbsi_prep (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic signed [31:0]    i_origin,
    input  logic signed [31:0]    i_dir,
    input  logic signed [31:0]    i_bmin,
    input  logic signed [31:0]    i_bmax,
    input  logic [15:0]           i_thr,
    output rbsi_pkg::t_div_in     o_div_min,
    output rbsi_pkg::t_div_in     o_div_max,
    output rbsi_pkg::t_axis_flags o_flags
);
    import rbsi_pkg::*;

    logic signed [32:0]    diff_min, diff_max;
    logic        [DEN_W-1:0] dmag;
    t_div_in               n_min, n_max;
    t_axis_flags           n_flags;
    t_div_in               r_min, r_max;
    t_axis_flags           r_flags;

    // Numerator magnitude is |diff| << 16; the sign is handled separately.
    function automatic logic [NUM_W-1:0] mag_shift(input logic signed [32:0] v);
        logic [32:0] m;
        m = v[32] ? 33'(-v) : 33'(v);
        return {m, 16'b0};
    endfunction

    always_comb begin
        diff_min = 33'(i_bmin) - 33'(i_origin);
        diff_max = 33'(i_bmax) - 33'(i_origin);
        dmag     = i_dir[31] ? 32'(-i_dir) : 32'(i_dir);

        n_min.num = mag_shift(diff_min);
        n_min.den = dmag;
        n_min.neg = diff_min[32] ^ i_dir[31];
        n_max.num = mag_shift(diff_max);
        n_max.den = dmag;
        n_max.neg = diff_max[32] ^ i_dir[31];

        n_flags.par     = (dmag <= {16'b0, i_thr});
        n_flags.in_slab = !((i_origin < i_bmin) || (i_origin > i_bmax));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_min   <= n_min;
            r_max   <= n_max;
            r_flags <= n_flags;
        end
    end

    assign o_div_min = r_min;
    assign o_div_max = r_max;
    assign o_flags   = r_flags;

endmodule

// ===== hw/rtl/rbsi_div.sv =====
// ============================================================================
// rbsi_div
// Pipelined restoring divider, one quotient bit per stage, saturating.
// ============================================================================
module rbsi_div (
    input  logic               i_clk,
    input  logic               i_en,
    input  rbsi_pkg::t_div_in  i_op,
    output logic signed [31:0] o_quot
);
    import rbsi_pkg::*;

    logic [REM_W-1:0] r_rem [QBITS+1];
    logic [DEN_W-1:0] r_den [QBITS+1];
    logic [QBITS-1:0] r_q   [QBITS+1];
    logic             r_neg [QBITS+1];
    logic             r_sat [QBITS+1];
    logic signed [31:0] r_out;
    logic [QBITS-1:0]   fin_mag;

    // First stage: a quotient of 2^31 or more saturates.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= REM_W'(i_op.num);
            r_den[0] <= i_op.den;
            r_q[0]   <= '0;
            r_neg[0] <= i_op.neg;
            r_sat[0] <= (REM_W'(i_op.num) >= {1'b0, i_op.den, 31'b0});
        end
    end

    for (genvar k = 1; k <= QBITS; k++) begin : g_stage
        localparam int unsigned B = QBITS - k;
        logic [REM_W-1:0] trial;
        logic             take;
        assign trial = REM_W'(r_den[k-1]) << B;
        assign take  = (r_rem[k-1] >= trial);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= take ? (r_rem[k-1] - trial) : r_rem[k-1];
                r_den[k] <= r_den[k-1];
                r_q[k]   <= r_q[k-1] | (take ? (QBITS'(1) << B) : '0);
                r_neg[k] <= r_neg[k-1];
                r_sat[k] <= r_sat[k-1];
            end
        end
    end

    assign fin_mag = r_sat[QBITS] ? QMAX : r_q[QBITS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= r_neg[QBITS] ? -$signed({1'b0, fin_mag}) : $signed({1'b0, fin_mag});
        end
    end

    assign o_quot = r_out;

endmodule

// ===== hw/rtl/rbsi_merge.sv =====
// ============================================================================
// rbsi_merge
// Intersects the per-axis intervals and forms the hit flag and distance.
// ============================================================================
module rbsi_merge (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic signed [31:0]    i_t_min [3],
    input  logic signed [31:0]    i_t_max [3],
    input  rbsi_pkg::t_axis_flags i_flags [3],
    output logic                  o_hit,
    output logic [30:0]           o_distance
);
    import rbsi_pkg::*;

    logic signed [31:0] lo, hi, a, b;
    logic               ok;
    logic               r_hit;
    logic [30:0]        r_dist;

    always_comb begin
        lo = QMAX_NEG;
        hi = QMAX_POS;
        ok = 1'b1;
        for (int i = 0; i < NAXES; i++) begin
            a = (i_t_min[i] > i_t_max[i]) ? i_t_max[i] : i_t_min[i];
            b = (i_t_min[i] > i_t_max[i]) ? i_t_min[i] : i_t_max[i];
            if (i_flags[i].par) begin
                ok = ok & i_flags[i].in_slab;
            end else begin
                if (a > lo) lo = a;
                if (b < hi) hi = b;
            end
        end
        ok = ok & (lo <= hi) & !hi[31];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hit  <= ok;
            r_dist <= ok ? (lo[31] ? hi[30:0] : lo[30:0]) : '0;
        end
    end

    assign o_hit      = r_hit;
    assign o_distance = r_dist;

endmodule

// ===== hw/rtl/ray_box_slab_intersect.sv =====
// ============================================================================
// ray_box_slab_intersect
// Ray against axis-aligned box slab test in signed Q16.16, fully pipelined.
// ============================================================================
// Usage: each input beat carries one ray (origin, direction) and one box
// (lower and upper corner), all signed Q16.16. Each output beat carries the
// hit flag and the nearest non-negative distance, saturated, zero on a miss.
// Both channels use valid/ready. The whole pipeline advances together
// whenever the output register is empty or being taken, so a new beat can
// enter every cycle and one result leaves every cycle: throughput is one
// item per cycle. There are 35 register stages: one prep stage, 33 divider
// stages (an overflow check, one stage per quotient bit for 31 bits, set by
// the restoring divider, and the signed output) and one merge stage that is
// also the output register. When the receiver stalls, every stage holds and
// input ready drops, so no beat is lost or repeated. Reset clears all valid
// bits and sets the parallel threshold to zero; data registers are not
// reset. The APB port holds parallel_threshold at address 0.
// ============================================================================
module ray_box_slab_intersect (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_origin_x,
    input  logic signed [31:0] i_origin_y,
    input  logic signed [31:0] i_origin_z,
    input  logic signed [31:0] i_dir_x,
    input  logic signed [31:0] i_dir_y,
    input  logic signed [31:0] i_dir_z,
    input  logic signed [31:0] i_box_min_x,
    input  logic signed [31:0] i_box_min_y,
    input  logic signed [31:0] i_box_min_z,
    input  logic signed [31:0] i_box_max_x,
    input  logic signed [31:0] i_box_max_y,
    input  logic signed [31:0] i_box_max_z,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_hit,
    output logic [30:0]        o_distance
);
    import rbsi_pkg::*;

    localparam int unsigned NSTG = DIV_LAT + 2;

    logic [15:0]        r_thr;
    logic [NSTG-1:0]    r_vld;
    logic               en;

    logic signed [31:0] org [3];
    logic signed [31:0] dir [3];
    logic signed [31:0] bmn [3];
    logic signed [31:0] bmx [3];

    t_div_in            div_min [3];
    t_div_in            div_max [3];
    t_axis_flags        pflags  [3];
    logic signed [31:0] t_min   [3];
    logic signed [31:0] t_max   [3];
    t_axis_flags        r_fl [DIV_LAT][3];
    t_axis_flags        mflags  [3];

    // Configuration register; writes complete in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_PAR_THR) begin
            r_thr <= pwdata[15:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_PAR_THR) ? {16'b0, r_thr} : '0;

    // One global advance: the pipeline moves when the output slot frees up.
    assign en          = !r_vld[NSTG-1] || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_in_valid};
        end
    end

    assign org = '{i_origin_x, i_origin_y, i_origin_z};
    assign dir = '{i_dir_x, i_dir_y, i_dir_z};
    assign bmn = '{i_box_min_x, i_box_min_y, i_box_min_z};
    assign bmx = '{i_box_max_x, i_box_max_y, i_box_max_z};

    for (genvar a = 0; a < NAXES; a++) begin : g_axis
        rbsi_prep u_prep (
            .i_clk     (i_clk),
            .i_en      (en),
            .i_origin  (org[a]),
            .i_dir     (dir[a]),
            .i_bmin    (bmn[a]),
            .i_bmax    (bmx[a]),
            .i_thr     (r_thr),
            .o_div_min (div_min[a]),
            .o_div_max (div_max[a]),
            .o_flags   (pflags[a])
        );

        rbsi_div u_div_min (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_op   (div_min[a]),
            .o_quot (t_min[a])
        );

        rbsi_div u_div_max (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_op   (div_max[a]),
            .o_quot (t_max[a])
        );

        // The parallel and in-slab flags ride alongside the divider.
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_fl[0][a] <= pflags[a];
                for (int s = 1; s < DIV_LAT; s++) begin
                    r_fl[s][a] <= r_fl[s-1][a];
                end
            end
        end

        assign mflags[a] = r_fl[DIV_LAT-1][a];
    end

    rbsi_merge u_merge (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_t_min    (t_min),
        .i_t_max    (t_max),
        .i_flags    (mflags),
        .o_hit      (o_hit),
        .o_distance (o_distance)
    );

endmodule

// ===== verif/ray_box_slab_intersect_tb.sv =====
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_tb
// Self-checking bench for the Q16.16 ray/box slab test. Beats are queued by a
// stimulus process, sent by a clocked driver with random gaps, and results
// are compared in order against a behavioral slab predictor.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rbsi_pkg::*;

    // One ray/box query as it goes over the input channel.
    typedef struct {
        logic signed [31:0] org [3];
        logic signed [31:0] dir [3];
        logic signed [31:0] bmin [3];
        logic signed [31:0] bmax [3];
    } t_ray_query;

    typedef struct {
        logic        hit;
        logic [30:0] distance;
    } t_hit_result;

    localparam longint SAT = 64'sd2147483647;
    localparam int LATENCY = 36;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic signed [31:0] in_org [3] = '{default: '0};
    logic signed [31:0] in_dir [3] = '{default: '0};
    logic signed [31:0] in_bmin [3] = '{default: '0};
    logic signed [31:0] in_bmax [3] = '{default: '0};
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic o_hit;
    logic [30:0] o_distance;

    t_ray_query  pending_rays [$];
    t_hit_result expected_hits [$];
    logic [15:0] model_thr = '0;
    int          error_count = 0;
    int          send_wait = 0;
    int          recv_wait = 0;
    int          hold_off = 0;
    bit          hold_start = 1'b0;
    bit          hold_taken = 1'b0;

    always #10 i_clk = ~i_clk;

    ray_box_slab_intersect uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_origin_x(in_org[0]), .i_origin_y(in_org[1]), .i_origin_z(in_org[2]),
        .i_dir_x(in_dir[0]), .i_dir_y(in_dir[1]), .i_dir_z(in_dir[2]),
        .i_box_min_x(in_bmin[0]), .i_box_min_y(in_bmin[1]),
        .i_box_min_z(in_bmin[2]),
        .i_box_max_x(in_bmax[0]), .i_box_max_y(in_bmax[1]),
        .i_box_max_z(in_bmax[2]),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_hit(o_hit), .o_distance(o_distance)
    );

    // Clamp a distance to the symmetric Q16.16 range.
    function automatic longint clamp_q(longint v);
        if (v > SAT) return SAT;
        if (v < -SAT) return -SAT;
        return v;
    endfunction

    // Slab test: narrow [near, far] per axis, parallel axes only check
    // containment of the origin. Division truncates toward zero as in C.
    function automatic t_hit_result slab_hit(t_ray_query q, logic [15:0] thr);
        t_hit_result r;
        longint near, far, o, d, lo_b, hi_b, t1, t2, sw, mag;
        bit ok;
        near = -SAT;
        far = SAT;
        ok = 1'b1;
        for (int a = 0; a < 3 && ok; a++) begin
            o = q.org[a];
            d = q.dir[a];
            lo_b = q.bmin[a];
            hi_b = q.bmax[a];
            mag = (d < 0) ? -d : d;
            if (mag <= longint'(thr)) begin
                ok = !(o < lo_b || o > hi_b);
            end else begin
                t1 = clamp_q(((lo_b - o) * 65536) / d);
                t2 = clamp_q(((hi_b - o) * 65536) / d);
                if (t1 > t2) begin
                    sw = t1; t1 = t2; t2 = sw;
                end
                if (t1 > near) near = t1;
                if (t2 < far) far = t2;
                ok = (near <= far);
            end
        end
        if (ok && far < 0) ok = 1'b0;
        r.hit = ok;
        r.distance = ok ? ((near >= 0) ? near[30:0] : far[30:0]) : '0;
        return r;
    endfunction

    // Driver: present queued beats with a random gap before each one; a gap
    // of zero puts the next beat right behind the accepted one.
    always @(posedge i_clk) begin
        int gap;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                expected_hits.push_back(slab_hit(pending_rays.pop_front(), model_thr));
                gap = $urandom_range(0, 8);
                if (gap == 0 && pending_rays.size() > 0) begin
                    in_org <= pending_rays[0].org;
                    in_dir <= pending_rays[0].dir;
                    in_bmin <= pending_rays[0].bmin;
                    in_bmax <= pending_rays[0].bmax;
                    i_in_valid <= 1'b1;
                end else begin
                    send_wait <= gap;
                    i_in_valid <= 1'b0;
                end
            end else if (!i_in_valid) begin
                if (send_wait > 0) begin
                    send_wait <= send_wait - 1;
                end else if (pending_rays.size() > 0) begin
                    in_org <= pending_rays[0].org;
                    in_dir <= pending_rays[0].dir;
                    in_bmin <= pending_rays[0].bmin;
                    in_bmax <= pending_rays[0].bmax;
                    i_in_valid <= 1'b1;
                end
            end
        end
    end

    // Long receiver hold-off so the pipeline fills and backs up the input.
    always @(posedge i_clk) begin
        if (hold_start && !hold_taken) begin
            hold_off <= 150;
            hold_taken <= 1'b1;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
        end
    end

    // Monitor: take each result beat and check it against the oldest
    // prediction; ready is dropped for a random number of cycles per beat.
    always @(posedge i_clk) begin
        t_hit_result want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_hits.size() == 0) begin
                    $display("%0t: result beat with nothing expected: hit=%0d dist=%h",
                             $time, o_hit, o_distance);
                    error_count++;
                end else begin
                    want = expected_hits.pop_front();
                    if (o_hit !== want.hit) begin
                        $display("%0t: hit expected %0d actual %0d",
                                 $time, want.hit, o_hit);
                        error_count++;
                    end
                    if (o_distance !== want.distance) begin
                        $display("%0t: distance expected %h actual %h",
                                 $time, want.distance, o_distance);
                        error_count++;
                    end
                end
                recv_wait = $urandom_range(0, 8);
            end
            if (hold_off > 0) begin
                i_out_ready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic write_threshold(input logic [15:0] thr);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_PAR_THR;
        pwdata <= {16'h0, thr};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        model_thr = thr;
    endtask

    task automatic drain_pipe();
        while (pending_rays.size() > 0 || i_in_valid || expected_hits.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Random value that often lands on an edge of the signed range.
    function automatic logic signed [31:0] edge_or_rand();
        case ($urandom_range(0, 7))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'sh0;
            default: return $urandom;
        endcase
    endfunction

    // Mostly well-formed query: modest box around the origin neighborhood, direction
    // large enough to usually be a real slab, sometimes parallel or zero, or edge values.
    function automatic t_ray_query make_query();
        t_ray_query q;
        int c;
        int signed lo, span;
        for (int a = 0; a < 3; a++) begin
            if ($urandom_range(0, 9) == 0) begin
                q.org[a] = edge_or_rand(); q.dir[a] = edge_or_rand();
                q.bmin[a] = edge_or_rand(); q.bmax[a] = edge_or_rand();
            end else begin
                q.org[a] = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
                c = $urandom_range(0, 9);
                if (c == 0) q.dir[a] = 0;
                else if (c == 1) q.dir[a] = $signed($urandom_range(0, 32'h2_0000)) - 32'sh1_0000;
                else q.dir[a] = $signed($urandom_range(0, 32'h8_0000)) - 32'sh4_0000;
                lo = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
                span = $urandom_range(0, 32'h0020_0000);
                q.bmin[a] = lo;
                q.bmax[a] = ($urandom_range(0, 15) == 0) ? lo - span : lo + span;
            end
        end
        return q;
    endfunction

    function automatic t_ray_query axis_query(logic signed [31:0] o, logic signed [31:0] d,
                                              logic signed [31:0] mn, logic signed [31:0] mx);
        t_ray_query q;
        for (int a = 0; a < 3; a++) begin
            q.org[a] = o; q.dir[a] = d; q.bmin[a] = mn; q.bmax[a] = mx;
        end
        return q;
    endfunction

    initial begin
        t_ray_query q;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats with the threshold at its reset value of zero.
        pending_rays.push_back(axis_query(0, 0, -32'sh1_0000, 32'sh1_0000));   // all parallel, inside
        pending_rays.push_back(axis_query(32'sh5_0000, 0, 0, 32'sh1_0000));    // parallel, outside
        pending_rays.push_back(axis_query(0, 0, 32'sh1_0000, -32'sh1_0000));   // inverted, parallel
        pending_rays.push_back(axis_query(0, 32'sh1_0000, 32'sh2_0000, 32'sh3_0000)); // hit ahead
        pending_rays.push_back(axis_query(0, 32'sh1_0000, 32'sh3_0000, 32'sh2_0000)); // inverted slab
        pending_rays.push_back(axis_query(0, -32'sh1_0000, -32'sh3_0000, -32'sh2_0000));
        pending_rays.push_back(axis_query(0, 32'sh1_0000, -32'sh3_0000, -32'sh2_0000)); // behind
        pending_rays.push_back(axis_query(0, 32'sh1_0000, -32'sh1_0000, 32'sh1_0000));  // inside
        pending_rays.push_back(axis_query(32'sh8000_0000, 1, 32'sh8000_0000, 32'sh7FFF_FFFF));
        pending_rays.push_back(axis_query(32'sh8000_0000, 32'sh7FFF_FFFF,
                                          32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
        pending_rays.push_back(axis_query(32'sh7FFF_FFFF, 32'sh8000_0000,
                                          32'sh8000_0000, 32'sh8000_0000));
        pending_rays.push_back(axis_query(-1, -1, -1, -1));
        pending_rays.push_back(axis_query(0, 32'sh1_0000, 32'sh1_0000, 32'sh1_0000));
        drain_pipe();

        // Threshold at its top value: small directions become parallel.
        write_threshold(16'hFFFF);
        pending_rays.push_back(axis_query(0, 32'sh0_FFFF, -32'sh1_0000, 32'sh1_0000));
        pending_rays.push_back(axis_query(0, -32'sh0_FFFF, 32'sh1_0000, 32'sh2_0000));
        pending_rays.push_back(axis_query(0, 32'sh1_0000, 32'sh1_0000, 32'sh2_0000));
        pending_rays.push_back(axis_query(0, -32'sh1_0000, -32'sh2_0000, -32'sh1_0000));
        for (int i = 0; i < 80; i++) pending_rays.push_back(make_query());
        // Stall the receiver for a long stretch while beats keep coming.
        hold_start = 1'b1;
        drain_pipe();

        write_threshold(16'h0000);
        for (int i = 0; i < 120; i++) pending_rays.push_back(make_query());
        drain_pipe();

        write_threshold(16'h8000);
        for (int i = 0; i < 100; i++) pending_rays.push_back(make_query());
        drain_pipe();

        write_threshold(16'($urandom_range(1, 16'hFFFE)));
        for (int i = 0; i < 100; i++) begin
            q = make_query();
            if ($urandom_range(0, 3) == 0) begin
                for (int a = 0; a < 3; a++) begin
                    q.org[a] = $urandom; q.dir[a] = $urandom;
                    q.bmin[a] = $urandom; q.bmax[a] = $urandom;
                end
            end
            pending_rays.push_back(q);
        end
        drain_pipe();
        repeat (LATENCY + 10) @(posedge i_clk);

        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule
